// ===== rtl/scgb_pkg.sv =====
// Shared constants, types and character codes of the serial command GPIO bridge.
package scgb_pkg;

    localparam int LINE_LEN  = 10;
    localparam int PORT_BITS = 16;
    localparam int OUT_W     = 16;
    localparam int NPORT     = 3;
    localparam int POS_W     = $clog2(LINE_LEN + 1);
    localparam int PIN_W     = 4;
    localparam int CAP_END   = 8;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_R     = 8'h52;

    typedef enum logic [1:0] {
        OP_DIR  = 2'd0,
        OP_OUT  = 2'd1,
        OP_READ = 2'd2,
        OP_ERR  = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [1:0]       port;
        logic [PIN_W-1:0] pin;
        logic             val;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        t_cmd head;
    } t_q_stat;

endpackage

// ===== rtl/scgb_front.sv =====
// Front end: line position tracking, character capture and command decode.
module scgb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rx_valid,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_q_full,
    output logic          o_push,
    output scgb_pkg::t_cmd o_cmd
);

    logic [scgb_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                 r_cap [4];
    logic [7:0]                 n_cap [4];
    logic                       rx_acc;

    function automatic scgb_pkg::t_cmd classify(input logic [7:0] c_cmd,
                                                input logic [7:0] c_port,
                                                input logic [7:0] c_pin,
                                                input logic [7:0] c_val);
        scgb_pkg::t_cmd r;
        logic           pin_ok;
        logic           port_ok;
        logic           cmd_ok;
        logic           val_ok;
        logic [7:0]     pin_full;
        r        = '0;
        pin_ok   = 1'b1;
        pin_full = '0;
        if (c_pin >= scgb_pkg::CH_A && c_pin <= scgb_pkg::CH_D) begin
            pin_full = c_pin - scgb_pkg::CH_A + 8'd10;
        end else if (c_pin >= scgb_pkg::CH_0 && c_pin <= scgb_pkg::CH_9) begin
            pin_full = c_pin - scgb_pkg::CH_0;
        end else begin
            pin_ok = 1'b0;
        end
        port_ok = (c_port >= scgb_pkg::CH_A) && (c_port <= scgb_pkg::CH_C);
        cmd_ok  = (c_cmd == scgb_pkg::CH_D) || (c_cmd == scgb_pkg::CH_O) ||
                  (c_cmd == scgb_pkg::CH_I);
        val_ok  = (c_val == scgb_pkg::CH_0) || (c_val == scgb_pkg::CH_1);
        r.pin   = pin_full[scgb_pkg::PIN_W-1:0];
        r.port  = 2'(c_port - scgb_pkg::CH_A);
        r.val   = c_val[0];
        if (!cmd_ok || !pin_ok || !port_ok) begin
            r.op = scgb_pkg::OP_ERR;
        end else if (c_cmd == scgb_pkg::CH_I) begin
            r.op = scgb_pkg::OP_READ;
        end else if (!val_ok) begin
            r.op = scgb_pkg::OP_ERR;
        end else if (c_cmd == scgb_pkg::CH_D) begin
            r.op = scgb_pkg::OP_DIR;
        end else begin
            r.op = scgb_pkg::OP_OUT;
        end
        return r;
    endfunction

    assign rx_acc = i_rx_valid && !i_q_full;

    always_comb begin
        n_pos  = r_pos;
        n_cap  = r_cap;
        o_push = 1'b0;
        if (rx_acc && i_rx_byte != scgb_pkg::CH_NUL) begin
            if (r_pos < scgb_pkg::POS_W'(scgb_pkg::LINE_LEN)) begin
                // odd positions below 8 hold cmd, port, pin, value
                if (r_pos[0] && r_pos < scgb_pkg::POS_W'(scgb_pkg::CAP_END)) begin
                    n_cap[r_pos[2:1]] = i_rx_byte;
                end
                n_pos = r_pos + 1'b1;
            end
            if (i_rx_byte == scgb_pkg::CH_NL) begin
                n_pos  = '0;
                o_push = 1'b1;
            end
        end
    end

    // decode sees a newline that landed on a capture slot
    assign o_cmd = classify(n_cap[0], n_cap[1], n_cap[2], n_cap[3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            for (int k = 0; k < 4; k++) begin
                r_cap[k] <= '0;
            end
        end else begin
            r_pos <= n_pos;
            r_cap <= n_cap;
        end
    end

endmodule

// ===== rtl/scgb_queue.sv =====
// Small command queue between decode and execution.
module scgb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  scgb_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output scgb_pkg::t_q_stat o_stat
);

    scgb_pkg::t_cmd              r_mem [scgb_pkg::QDEPTH];
    logic [scgb_pkg::QPTR_W-1:0] r_wp, n_wp;
    logic [scgb_pkg::QPTR_W-1:0] r_rp, n_rp;
    logic [scgb_pkg::QCNT_W-1:0] r_cnt, n_cnt;
    logic                        do_push;
    logic                        do_pop;

    function automatic logic [scgb_pkg::QPTR_W-1:0] wrap_inc(
        input logic [scgb_pkg::QPTR_W-1:0] p);
        return (p == scgb_pkg::QPTR_W'(scgb_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == scgb_pkg::QCNT_W'(scgb_pkg::QDEPTH));
    assign o_stat.head  = r_mem[r_rp];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wp  = do_push ? wrap_inc(r_wp) : r_wp;
        n_rp  = do_pop ? wrap_inc(r_rp) : r_rp;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/scgb_back.sv =====
// Back end: GPIO register updates and reply character sequencing.
module scgb_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  scgb_pkg::t_q_stat              i_q,
    output logic                           o_pop,
    output logic                           o_tx_valid,
    input  logic                           i_tx_stall,
    output logic [7:0]                     o_tx_char,
    output logic                           o_tx_last,
    output logic [scgb_pkg::PORT_BITS-1:0] o_dir [scgb_pkg::NPORT],
    output logic [scgb_pkg::PORT_BITS-1:0] o_out [scgb_pkg::NPORT]
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } t_state;

    t_state                       r_state, n_state;
    scgb_pkg::t_op                r_op, n_op;
    logic [2:0]                   r_idx, n_idx;
    logic                         r_pibit, n_pibit;
    logic [scgb_pkg::PORT_BITS-1:0] r_dir [scgb_pkg::NPORT];
    logic [scgb_pkg::PORT_BITS-1:0] n_dir [scgb_pkg::NPORT];
    logic [scgb_pkg::PORT_BITS-1:0] r_out [scgb_pkg::NPORT];
    logic [scgb_pkg::PORT_BITS-1:0] n_out [scgb_pkg::NPORT];
    logic [scgb_pkg::PORT_BITS-1:0] pin_mask;
    logic [2:0]                   last_idx;
    logic                         tx_acc;
    logic                         finish;

    function automatic logic [7:0] reply_char(input scgb_pkg::t_op op,
                                              input logic [2:0] idx,
                                              input logic pibit);
        logic [7:0] c;
        c = scgb_pkg::CH_NL;
        unique case (op)
            scgb_pkg::OP_DIR, scgb_pkg::OP_OUT: begin
                if (idx == 3'd0) c = scgb_pkg::CH_O;
                else if (idx == 3'd1) c = scgb_pkg::CH_K;
            end
            scgb_pkg::OP_READ: begin
                if (idx == 3'd0) c = scgb_pkg::CH_P;
                else if (idx == 3'd1) c = scgb_pkg::CH_I;
                else if (idx == 3'd2) c = scgb_pkg::CH_COMMA;
                else if (idx == 3'd3) c = pibit ? scgb_pkg::CH_1 : scgb_pkg::CH_0;
            end
            scgb_pkg::OP_ERR: begin
                if (idx == 3'd0) c = scgb_pkg::CH_E;
                else if (idx == 3'd1) c = scgb_pkg::CH_R;
                else if (idx == 3'd2) c = scgb_pkg::CH_R;
                else if (idx == 3'd3) c = scgb_pkg::CH_O;
                else if (idx == 3'd4) c = scgb_pkg::CH_R;
            end
        endcase
        return c;
    endfunction

    always_comb begin
        unique case (r_op)
            scgb_pkg::OP_DIR, scgb_pkg::OP_OUT: last_idx = 3'd2;
            scgb_pkg::OP_READ:                  last_idx = 3'd4;
            scgb_pkg::OP_ERR:                   last_idx = 3'd5;
        endcase
    end

    assign o_tx_valid = (r_state == ST_SEND);
    assign o_tx_char  = reply_char(r_op, r_idx, r_pibit);
    assign o_tx_last  = (r_idx == last_idx);
    assign tx_acc     = o_tx_valid && !i_tx_stall;
    assign finish     = tx_acc && o_tx_last;
    assign o_pop      = !i_q.empty && ((r_state == ST_IDLE) || finish);
    assign o_dir      = r_dir;
    assign o_out      = r_out;

    assign pin_mask = scgb_pkg::PORT_BITS'(1) << i_q.head.pin;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_idx   = r_idx;
        n_pibit = r_pibit;
        n_dir   = r_dir;
        n_out   = r_out;
        if (o_pop) begin
            // register writes land before the first reply beat
            n_state = ST_SEND;
            n_op    = i_q.head.op;
            n_idx   = '0;
            for (int k = 0; k < scgb_pkg::NPORT; k++) begin
                if (i_q.head.port == 2'(k)) begin
                    n_pibit = |(r_out[k] & pin_mask);
                    if (i_q.head.op == scgb_pkg::OP_DIR) begin
                        n_dir[k] = i_q.head.val ? (r_dir[k] | pin_mask)
                                                : (r_dir[k] & ~pin_mask);
                    end
                    if (i_q.head.op == scgb_pkg::OP_OUT) begin
                        n_out[k] = i_q.head.val ? (r_out[k] | pin_mask)
                                                : (r_out[k] & ~pin_mask);
                    end
                end
            end
        end else if (finish) begin
            n_state = ST_IDLE;
        end else if (tx_acc) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= scgb_pkg::OP_ERR;
            r_idx   <= '0;
            r_pibit <= 1'b0;
            for (int k = 0; k < scgb_pkg::NPORT; k++) begin
                r_dir[k] <= '0;
                r_out[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_idx   <= n_idx;
            r_pibit <= n_pibit;
            r_dir   <= n_dir;
            r_out   <= n_out;
        end
    end

    // GPIO state only moves when a new command starts
    a_regs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEND && !finish) |=>
            ($stable(r_dir[0]) && $stable(r_dir[1]) && $stable(r_dir[2]) &&
             $stable(r_out[0]) && $stable(r_out[1]) && $stable(r_out[2])))
        else $error("GPIO registers changed mid-reply");

    a_pop_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == ST_IDLE || finish))
        else $error("command popped while a reply is still pending");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEND) |-> (r_idx <= last_idx))
        else $error("reply index ran past the last character");

    a_last_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && i_q.empty) |=> (r_state == ST_IDLE))
        else $error("reply did not end after its last beat");

endmodule

// ===== rtl/serial_command_gpio_bridge.sv =====
// Top level of the serial command GPIO bridge: front decode, command queue, executor.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------
//  rx in    | i_rx_valid / o_rx_stall   | i_rx_byte
//  tx out   | o_tx_valid / i_tx_stall   | o_tx_char, o_tx_last
//
// The front end takes received bytes back to back while the queue has room.
// A newline pushes one decoded command into a two-entry queue; the executor
// then replies OK, PI,x or ERROR, each ended by a newline.
// The tx port is the limit: one reply beat per cycle while i_tx_stall is low, so the executor sets the rate.
// Reset (i_rst_n low, synchronous) clears position, captures, GPIO state and queue.
// o_rx_stall rises only while the queue is full; i_tx_stall holds the current beat.
module serial_command_gpio_bridge (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rx_valid,
    output logic                     o_rx_stall,
    input  logic [7:0]               i_rx_byte,
    output logic                     o_tx_valid,
    input  logic                     i_tx_stall,
    output logic [7:0]               o_tx_char,
    output logic                     o_tx_last,
    output logic [scgb_pkg::OUT_W-1:0] o_dir_a,
    output logic [scgb_pkg::OUT_W-1:0] o_dir_b,
    output logic [scgb_pkg::OUT_W-1:0] o_dir_c,
    output logic [scgb_pkg::OUT_W-1:0] o_out_a,
    output logic [scgb_pkg::OUT_W-1:0] o_out_b,
    output logic [scgb_pkg::OUT_W-1:0] o_out_c
);

    logic                           push;
    scgb_pkg::t_cmd                 cmd;
    logic                           pop;
    scgb_pkg::t_q_stat              q_stat;
    logic [scgb_pkg::PORT_BITS-1:0] dir [scgb_pkg::NPORT];
    logic [scgb_pkg::PORT_BITS-1:0] outl [scgb_pkg::NPORT];

    // input side backs off only when the queue has no room
    assign o_rx_stall = q_stat.full;

    scgb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (q_stat.full),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    scgb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_stat  (q_stat)
    );

    scgb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q        (q_stat),
        .o_pop      (pop),
        .o_tx_valid (o_tx_valid),
        .i_tx_stall (i_tx_stall),
        .o_tx_char  (o_tx_char),
        .o_tx_last  (o_tx_last),
        .o_dir      (dir),
        .o_out      (outl)
    );

    // reported GPIO words are fixed width whatever the port size
    assign o_dir_a = scgb_pkg::OUT_W'(dir[0]);
    assign o_dir_b = scgb_pkg::OUT_W'(dir[1]);
    assign o_dir_c = scgb_pkg::OUT_W'(dir[2]);
    assign o_out_a = scgb_pkg::OUT_W'(outl[0]);
    assign o_out_b = scgb_pkg::OUT_W'(outl[1]);
    assign o_out_c = scgb_pkg::OUT_W'(outl[2]);

endmodule
